/* rtl/zmpk_pkg.sv */
// Shared types, widths and fixed-point helpers for the zero-multipole pair kernel.
`default_nettype none

package zmpk_pkg;

   localparam int DATA_W    = 48;               // Q15.32 signed word
   localparam int DIST_W    = 47;               // unsigned distance powers
   localparam int FRAC_BITS = 32;
   localparam int HALF_W    = DATA_W / 2;       // multiplier split point
   localparam int PROD_W    = 2 * DATA_W;       // exact signed product
   localparam int EXT_W     = PROD_W + 4;       // product scaled by up to 8
   localparam int SUM_W     = DATA_W + 4;       // exact sum of the six terms
   localparam int CSR_IDX_W = 3;

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CORE_OFFSET = 3'd0,
      REG_COEFF_R2    = 3'd1,
      REG_COEFF_R4    = 3'd2,
      REG_COEFF_R6    = 3'd3,
      REG_COEFF_R8    = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic                     kind;
      logic signed [DATA_W-1:0] charge_product;
      logic [DIST_W-1:0]        dist_sq;
      logic [DIST_W-1:0]        dist_inv;
      logic [DIST_W-1:0]        dist_inv_cubed;
   } item_type;

   // Drop the fraction bits (floor) and clamp to the signed data word.
   function automatic logic signed [DATA_W-1:0] fix_sat(input logic signed [EXT_W-1:0] p);
      logic signed [EXT_W-1:0]  s;
      logic [EXT_W-DATA_W:0]    top;
      logic signed [DATA_W-1:0] r;
      s   = p >>> FRAC_BITS;
      top = s[EXT_W-1:DATA_W-1];
      priority if ((&top) || !(|top)) begin
         r = s[DATA_W-1:0];
      end else if (top[EXT_W-DATA_W]) begin
         r = DATA_MIN;
      end else begin
         r = DATA_MAX;
      end
      return r;
   endfunction

   // Clamp an exact sum to the signed data word.
   function automatic logic signed [DATA_W-1:0] sum_sat(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-DATA_W:0]    top;
      logic signed [DATA_W-1:0] r;
      top = v[SUM_W-1:DATA_W-1];
      priority if ((&top) || !(|top)) begin
         r = v[DATA_W-1:0];
      end else if (top[SUM_W-DATA_W]) begin
         r = DATA_MIN;
      end else begin
         r = DATA_MAX;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/zmpk_mul.sv */
// Two-stage signed multiplier built from four half-width partial products.
`default_nettype none

module zmpk_mul (
   input  wire logic                                  clock,
   input  wire logic signed [zmpk_pkg::DATA_W-1:0]    a,
   input  wire logic signed [zmpk_pkg::DATA_W-1:0]    b,
   output logic signed [zmpk_pkg::PROD_W-1:0]         p
);

   localparam int HW = zmpk_pkg::HALF_W;
   localparam int DW = zmpk_pkg::DATA_W;
   localparam int PW = zmpk_pkg::PROD_W;

   logic signed [DW-HW-1:0]   a_hi, b_hi;
   logic signed [HW:0]        a_lo, b_lo;
   logic signed [2*(DW-HW)-1:0] pp_hh_in, pp_hh_ff;
   logic signed [DW:0]        pp_hl_in, pp_hl_ff;
   logic signed [DW:0]        pp_lh_in, pp_lh_ff;
   logic signed [2*HW+1:0]    pp_ll_in, pp_ll_ff;
   logic signed [PW-1:0]      p_in, p_ff;

   // High halves carry the sign, low halves are unsigned.
   always_comb begin
      a_hi     = a[DW-1:HW];
      b_hi     = b[DW-1:HW];
      a_lo     = $signed({1'b0, a[HW-1:0]});
      b_lo     = $signed({1'b0, b[HW-1:0]});
      pp_hh_in = a_hi * b_hi;
      pp_hl_in = a_hi * b_lo;
      pp_lh_in = a_lo * b_hi;
      pp_ll_in = a_lo * b_lo;
   end

   always_comb begin
      p_in = (PW'(pp_hh_ff) <<< (2 * HW))
           + ((PW'(pp_hl_ff) + PW'(pp_lh_ff)) <<< HW)
           + PW'(pp_ll_ff);
   end

   always_ff @(posedge clock) begin
      pp_hh_ff <= pp_hh_in;
      pp_hl_ff <= pp_hl_in;
      pp_lh_ff <= pp_lh_in;
      pp_ll_ff <= pp_ll_in;
      p_ff     <= p_in;
   end

   assign p = p_ff;

endmodule

`default_nettype wire

/* rtl/zero_multipole_pair_kernel_unit.sv */
// Zero-multipole pair kernel: pair energy and force coefficient, fully pipelined.
`default_nettype none

// One atom pair enters per clock: the block never raises busy, so an item is
// taken at every edge where start is high. Its result is strobed on rsp_valid
// for one cycle, in the order the items came in; the receiver must take it
// then. The latency is set by the chain of dependent products r2 -> r4 ->
// r6/r8 -> coefficient terms, then the two sums and the final multiply by
// the charge product. Every product runs on a two-stage split multiplier
// followed by a truncate-and-saturate stage. All arithmetic is Q15.32 two's
// complement; products truncate toward minus infinity and every product and
// both sums saturate to 48 bits. Excluded pairs (kind = 1) drop the 1/r,
// core offset and 1/r^3 terms. Write the five csr registers (core offset,
// then the r^2, r^4, r^6 and r^8 coefficients) only while no item is in
// flight; writes to other indexes are ignored.

module zero_multipole_pair_kernel_unit (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // item channel
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire logic                                     req_kind,
   input  wire logic signed [zmpk_pkg::DATA_W-1:0]       req_charge_product,
   input  wire logic [zmpk_pkg::DIST_W-1:0]              req_dist_sq,
   input  wire logic [zmpk_pkg::DIST_W-1:0]              req_dist_inv,
   input  wire logic [zmpk_pkg::DIST_W-1:0]              req_dist_inv_cubed,
   // result channel
   output logic                                          rsp_valid,
   output logic signed [zmpk_pkg::DATA_W-1:0]            rsp_energy,
   output logic signed [zmpk_pkg::DATA_W-1:0]            rsp_force_coeff,
   // register write port
   input  wire logic                                     csr_we,
   input  wire logic [zmpk_pkg::CSR_IDX_W-1:0]           csr_index,
   input  wire logic [zmpk_pkg::DATA_W-1:0]              csr_wdata
);

   localparam int DW = zmpk_pkg::DATA_W;
   localparam int PW = zmpk_pkg::PROD_W;
   localparam int XW = zmpk_pkg::EXT_W;
   localparam int SW = zmpk_pkg::SUM_W;

   // Multiplier slots, grouped by the stage that feeds them.
   localparam int MUL_R2R2  = 0;   // stage 0: r4
   localparam int MUL_C2R2  = 1;   // stage 0: energy term
   localparam int MUL_C4R2  = 2;   // stage 0: force term (x4)
   localparam int MUL_R4R2  = 3;   // stage 3: r6
   localparam int MUL_R4R4  = 4;   // stage 3: r8
   localparam int MUL_C4R4  = 5;   // stage 3: energy term
   localparam int MUL_C6R4  = 6;   // stage 3: force term (x6)
   localparam int MUL_C6R6  = 7;   // stage 6: energy term
   localparam int MUL_C8R8  = 8;   // stage 6: energy term
   localparam int MUL_C8R6  = 9;   // stage 6: force term (x8)
   localparam int MUL_CC_SE = 10;  // stage 10: energy
   localparam int MUL_CC_SF = 11;  // stage 10: force coefficient
   localparam int NUM_MUL   = 12;

   localparam int ITEM_D    = 10;  // item fields are last needed at stage 10
   localparam int VALID_D   = 12;  // result register loads at stage 12
   localparam int HOLD_D    = 3;   // partial sums wait three stages per link

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic signed [DW-1:0] core_offset_ff, core_offset_in;
   logic signed [DW-1:0] coeff_r2_ff, coeff_r2_in;
   logic signed [DW-1:0] coeff_r4_ff, coeff_r4_in;
   logic signed [DW-1:0] coeff_r6_ff, coeff_r6_in;
   logic signed [DW-1:0] coeff_r8_ff, coeff_r8_in;

   always_comb begin
      core_offset_in = core_offset_ff;
      coeff_r2_in    = coeff_r2_ff;
      coeff_r4_in    = coeff_r4_ff;
      coeff_r6_in    = coeff_r6_ff;
      coeff_r8_in    = coeff_r8_ff;
      if (csr_we) begin
         unique case (csr_index)
            zmpk_pkg::REG_CORE_OFFSET: core_offset_in = csr_wdata;
            zmpk_pkg::REG_COEFF_R2:    coeff_r2_in    = csr_wdata;
            zmpk_pkg::REG_COEFF_R4:    coeff_r4_in    = csr_wdata;
            zmpk_pkg::REG_COEFF_R6:    coeff_r6_in    = csr_wdata;
            zmpk_pkg::REG_COEFF_R8:    coeff_r8_in    = csr_wdata;
            default: ;  // unknown index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         core_offset_ff <= '0;
         coeff_r2_ff    <= '0;
         coeff_r4_ff    <= '0;
         coeff_r6_ff    <= '0;
         coeff_r8_ff    <= '0;
      end else begin
         core_offset_ff <= core_offset_in;
         coeff_r2_ff    <= coeff_r2_in;
         coeff_r4_ff    <= coeff_r4_in;
         coeff_r6_ff    <= coeff_r6_in;
         coeff_r8_ff    <= coeff_r8_in;
      end
   end

   // ---------------------------------------------------------------------
   // Item and valid shift lines: the pipeline advances every cycle.
   // ---------------------------------------------------------------------
   zmpk_pkg::item_type   item_in;
   zmpk_pkg::item_type   item_ff [ITEM_D];
   logic                 valid_in;
   logic [VALID_D-1:0]   valid_ff;

   assign busy     = 1'b0;
   assign valid_in = start && !busy;

   always_comb begin
      item_in.kind           = req_kind;
      item_in.charge_product = req_charge_product;
      item_in.dist_sq        = req_dist_sq;
      item_in.dist_inv       = req_dist_inv;
      item_in.dist_inv_cubed = req_dist_inv_cubed;
   end

   always_ff @(posedge clock) begin
      item_ff[0] <= item_in;
      for (int i = 1; i < ITEM_D; i++) begin
         item_ff[i] <= item_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[VALID_D-2:0], valid_in};
      end
   end

   // ---------------------------------------------------------------------
   // Multiplier bank
   // ---------------------------------------------------------------------
   logic signed [DW-1:0] mul_a [NUM_MUL];
   logic signed [DW-1:0] mul_b [NUM_MUL];
   logic signed [PW-1:0] mul_p [NUM_MUL];

   for (genvar g = 0; g < NUM_MUL; g++) begin : g_mul
      zmpk_mul u_mul (
         .clock (clock),
         .a     (mul_a[g]),
         .b     (mul_b[g]),
         .p     (mul_p[g])
      );
   end

   // Stage registers along the dependency chain.
   logic signed [DW-1:0] r4_ff, r4_in;
   logic signed [DW-1:0] t_c2r2_ff, t_c2r2_in;
   logic signed [DW-1:0] t_4c4r2_ff, t_4c4r2_in;
   logic signed [SW-1:0] se_a_ff [HOLD_D];
   logic signed [SW-1:0] sf_a_ff [HOLD_D];
   logic signed [SW-1:0] se_a_in, sf_a_in;
   logic signed [DW-1:0] r6_ff, r6_in;
   logic signed [DW-1:0] r8_ff, r8_in;
   logic signed [DW-1:0] t_c4r4_ff, t_c4r4_in;
   logic signed [DW-1:0] t_6c6r4_ff, t_6c6r4_in;
   logic signed [SW-1:0] se_b_ff [HOLD_D];
   logic signed [SW-1:0] sf_b_ff [HOLD_D];
   logic signed [SW-1:0] se_b_in, sf_b_in;
   logic signed [DW-1:0] t_c6r6_ff, t_c6r6_in;
   logic signed [DW-1:0] t_c8r8_ff, t_c8r8_in;
   logic signed [DW-1:0] t_8c8r6_ff, t_8c8r6_in;
   logic signed [DW-1:0] se_sat_ff, se_sat_in;
   logic signed [DW-1:0] nsf_sat_ff, nsf_sat_in;
   logic signed [DW-1:0] rsp_energy_ff, rsp_energy_in;
   logic signed [DW-1:0] rsp_force_coeff_ff, rsp_force_coeff_in;
   logic                 rsp_valid_ff;

   // Working values for the final sums.
   logic signed [DW-1:0] op_r2_in, op_r2_s2;
   logic signed [XW-1:0] x_c6r4;
   logic signed [SW-1:0] near_se, near_sf, se_full, sf_full;
   zmpk_pkg::item_type   it_s8, it_s9;

   // Multiplier operands. Stage 0 reads the ports, later stages read the
   // registered powers and the item carried alongside.
   always_comb begin
      op_r2_in = $signed({1'b0, req_dist_sq});
      op_r2_s2 = $signed({1'b0, item_ff[2].dist_sq});
      it_s9    = item_ff[9];

      mul_a[MUL_R2R2]  = op_r2_in;     mul_b[MUL_R2R2]  = op_r2_in;
      mul_a[MUL_C2R2]  = coeff_r2_ff;  mul_b[MUL_C2R2]  = op_r2_in;
      mul_a[MUL_C4R2]  = coeff_r4_ff;  mul_b[MUL_C4R2]  = op_r2_in;
      mul_a[MUL_R4R2]  = r4_ff;        mul_b[MUL_R4R2]  = op_r2_s2;
      mul_a[MUL_R4R4]  = r4_ff;        mul_b[MUL_R4R4]  = r4_ff;
      mul_a[MUL_C4R4]  = coeff_r4_ff;  mul_b[MUL_C4R4]  = r4_ff;
      mul_a[MUL_C6R4]  = coeff_r6_ff;  mul_b[MUL_C6R4]  = r4_ff;
      mul_a[MUL_C6R6]  = coeff_r6_ff;  mul_b[MUL_C6R6]  = r6_ff;
      mul_a[MUL_C8R8]  = coeff_r8_ff;  mul_b[MUL_C8R8]  = r8_ff;
      mul_a[MUL_C8R6]  = coeff_r8_ff;  mul_b[MUL_C8R6]  = r6_ff;
      mul_a[MUL_CC_SE] = it_s9.charge_product; mul_b[MUL_CC_SE] = se_sat_ff;
      mul_a[MUL_CC_SF] = it_s9.charge_product; mul_b[MUL_CC_SF] = nsf_sat_ff;
   end

   // Truncate, scale and saturate each product; accumulate the polynomial
   // sums one link at a time so no stage adds more than a few terms.
   always_comb begin
      // stage 2: r4 and the r2 terms
      r4_in      = zmpk_pkg::fix_sat(XW'(mul_p[MUL_R2R2]));
      t_c2r2_in  = zmpk_pkg::fix_sat(XW'(mul_p[MUL_C2R2]));
      t_4c4r2_in = zmpk_pkg::fix_sat(XW'(mul_p[MUL_C4R2]) <<< 2);

      // stage 3: open the sums; 2*c2 is exact
      se_a_in = -SW'(t_c2r2_ff);
      sf_a_in = (SW'(coeff_r2_ff) <<< 1) + SW'(t_4c4r2_ff);

      // stage 5: r6, r8 and the r4 terms
      x_c6r4     = XW'(mul_p[MUL_C6R4]);
      r6_in      = zmpk_pkg::fix_sat(XW'(mul_p[MUL_R4R2]));
      r8_in      = zmpk_pkg::fix_sat(XW'(mul_p[MUL_R4R4]));
      t_c4r4_in  = zmpk_pkg::fix_sat(XW'(mul_p[MUL_C4R4]));
      t_6c6r4_in = zmpk_pkg::fix_sat((x_c6r4 <<< 2) + (x_c6r4 <<< 1));

      // stage 6: fold in the r4 terms
      se_b_in = se_a_ff[HOLD_D-1] - SW'(t_c4r4_ff);
      sf_b_in = sf_a_ff[HOLD_D-1] + SW'(t_6c6r4_ff);

      // stage 8: the r6 and r8 terms
      t_c6r6_in  = zmpk_pkg::fix_sat(XW'(mul_p[MUL_C6R6]));
      t_c8r8_in  = zmpk_pkg::fix_sat(XW'(mul_p[MUL_C8R8]));
      t_8c8r6_in = zmpk_pkg::fix_sat(XW'(mul_p[MUL_C8R6]) <<< 3);

      // stage 9: close the sums; excluded pairs drop the near-field terms
      it_s8 = item_ff[8];
      if (it_s8.kind) begin
         near_se = '0;
         near_sf = '0;
      end else begin
         near_se = $signed(SW'({1'b0, it_s8.dist_inv})) - SW'(core_offset_ff);
         near_sf = $signed(SW'({1'b0, it_s8.dist_inv_cubed}));
      end
      se_full    = se_b_ff[HOLD_D-1] - SW'(t_c6r6_ff) - SW'(t_c8r8_ff) + near_se;
      sf_full    = sf_b_ff[HOLD_D-1] + SW'(t_8c8r6_ff) + near_sf;
      se_sat_in  = zmpk_pkg::sum_sat(se_full);
      nsf_sat_in = zmpk_pkg::sum_sat(-sf_full);

      // stage 12: scale by the charge product
      rsp_energy_in      = zmpk_pkg::fix_sat(XW'(mul_p[MUL_CC_SE]));
      rsp_force_coeff_in = zmpk_pkg::fix_sat(XW'(mul_p[MUL_CC_SF]));
   end

   always_ff @(posedge clock) begin
      r4_ff      <= r4_in;
      t_c2r2_ff  <= t_c2r2_in;
      t_4c4r2_ff <= t_4c4r2_in;
      se_a_ff[0] <= se_a_in;
      sf_a_ff[0] <= sf_a_in;
      se_b_ff[0] <= se_b_in;
      sf_b_ff[0] <= sf_b_in;
      for (int i = 1; i < HOLD_D; i++) begin
         se_a_ff[i] <= se_a_ff[i-1];
         sf_a_ff[i] <= sf_a_ff[i-1];
         se_b_ff[i] <= se_b_ff[i-1];
         sf_b_ff[i] <= sf_b_ff[i-1];
      end
      r6_ff              <= r6_in;
      r8_ff              <= r8_in;
      t_c4r4_ff          <= t_c4r4_in;
      t_6c6r4_ff         <= t_6c6r4_in;
      t_c6r6_ff          <= t_c6r6_in;
      t_c8r8_ff          <= t_c8r8_in;
      t_8c8r6_ff         <= t_8c8r6_in;
      se_sat_ff          <= se_sat_in;
      nsf_sat_ff         <= nsf_sat_in;
      rsp_energy_ff      <= rsp_energy_in;
      rsp_force_coeff_ff <= rsp_force_coeff_in;
   end

   // Strobe the result from a register behind the last valid stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[VALID_D-1];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_energy      = rsp_energy_ff;
   assign rsp_force_coeff = rsp_force_coeff_ff;

endmodule

`default_nettype wire
